// ----- hdl/vau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector arithmetic unit package
// Opcodes and the record that travels down the pipeline with each item.
// ----------------------------------------------------------------------------
package vau_pkg;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_NEG   = 4'd2,
    OP_SCALE = 4'd3,
    OP_DOT   = 4'd4,
    OP_CROSS = 4'd5,
    OP_MAG   = 4'd6,
    OP_NORM  = 4'd7,
    OP_NULL  = 4'd8
  } op_e;

  typedef struct packed {
    logic [3:0]       op;
    logic [2:0][31:0] a;
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic             ov;
  } pipe_t;

  localparam int unsigned RootW  = 32;
  localparam int unsigned QuotW  = 17;

endpackage

// ----- hdl/vau_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector arithmetic front end
// Input register, six shared multipliers, then add, shift and saturation.
// ----------------------------------------------------------------------------
module vau_front import vau_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [3:0]       op_i,
  input  logic [2:0][31:0] a_i,
  input  logic [2:0][31:0] b_i,
  input  logic [31:0]      s_i,
  output logic             valid_o,
  output pipe_t            pipe_o,
  output logic [63:0]      sumsq_o
);

  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] res;
    if (v > 66'sd2147483647) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sd2147483648) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  logic             va_q;
  logic [3:0]       opa_q;
  logic [2:0][31:0] aa_q, ba_q;
  logic [31:0]      sa_q;

  logic             vb_q;
  logic [3:0]       opb_q;
  logic [2:0][31:0] ab_q, bb_q;
  logic signed [63:0] pb_q [6];
  logic signed [63:0] pb_d [6];

  logic             vc_q;
  pipe_t            pc_q, pc_d;
  logic [63:0]      sumsq_q, sumsq_d;

  logic signed [31:0] mx [6];
  logic signed [31:0] my [6];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mx[k] = aa_q[k];
      my[k] = ba_q[k];
    end
    mx[3] = aa_q[0]; my[3] = ba_q[2];
    mx[4] = aa_q[0]; my[4] = ba_q[1];
    mx[5] = aa_q[1]; my[5] = ba_q[0];
    case (opa_q)
      OP_SCALE: begin
        for (int k = 0; k < 3; k++) my[k] = sa_q;
      end
      OP_MAG, OP_NORM, OP_NULL: begin
        for (int k = 0; k < 3; k++) my[k] = aa_q[k];
      end
      OP_CROSS: begin
        mx[0] = aa_q[1]; my[0] = ba_q[2];
        mx[1] = aa_q[2]; my[1] = ba_q[1];
        mx[2] = aa_q[2]; my[2] = ba_q[0];
      end
      default: begin
      end
    endcase
    for (int k = 0; k < 6; k++) pb_d[k] = mx[k] * my[k];
  end

  logic signed [65:0] e [6];
  logic signed [65:0] ea [3];
  logic signed [65:0] eb [3];
  logic signed [65:0] esum;
  logic [32:0]        st [3];
  logic [32:0]        sd;

  always_comb begin
    for (int k = 0; k < 6; k++) e[k] = 66'(pb_q[k]);
    for (int k = 0; k < 3; k++) begin
      ea[k] = 66'($signed(ab_q[k]));
      eb[k] = 66'($signed(bb_q[k]));
      st[k] = '0;
    end
    esum    = e[0] + e[1] + e[2];
    sd      = '0;
    pc_d    = '0;
    pc_d.op = opb_q;
    pc_d.a  = ab_q;
    case (opb_q)
      OP_ADD: begin
        for (int k = 0; k < 3; k++) st[k] = sat32(ea[k] + eb[k]);
      end
      OP_SUB: begin
        for (int k = 0; k < 3; k++) st[k] = sat32(ea[k] - eb[k]);
      end
      OP_NEG: begin
        for (int k = 0; k < 3; k++) st[k] = sat32(-ea[k]);
      end
      OP_SCALE: begin
        for (int k = 0; k < 3; k++) st[k] = sat32(e[k] >>> 16);
      end
      OP_CROSS: begin
        st[0] = sat32((e[0] - e[1]) >>> 16);
        st[1] = sat32((e[2] - e[3]) >>> 16);
        st[2] = sat32((e[4] - e[5]) >>> 16);
      end
      OP_DOT: begin
        sd = sat32(esum >>> 16);
      end
      default: begin
      end
    endcase
    for (int k = 0; k < 3; k++) pc_d.r[k] = st[k][31:0];
    pc_d.sc = sd[31:0];
    pc_d.ov = st[0][32] | st[1][32] | st[2][32] | sd[32];
    sumsq_d = esum[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      opa_q <= op_i;
      aa_q  <= a_i;
      ba_q  <= b_i;
      sa_q  <= s_i;
      opb_q <= opa_q;
      ab_q  <= aa_q;
      bb_q  <= ba_q;
      for (int k = 0; k < 6; k++) pb_q[k] <= pb_d[k];
      pc_q    <= pc_d;
      sumsq_q <= sumsq_d;
    end
  end

  assign valid_o = vc_q;
  assign pipe_o  = pc_q;
  assign sumsq_o = sumsq_q;

endmodule

// ----- hdl/vau_sqrt_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root step
// Decides one root bit: keeps it when the remainder covers the square growth.
// ----------------------------------------------------------------------------
module vau_sqrt_step import vau_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pipe_t             pipe_i,
  input  logic [63:0]       rem_i,
  input  logic [RootW-1:0]  root_i,
  output logic              valid_o,
  output pipe_t             pipe_o,
  output logic [63:0]       rem_o,
  output logic [RootW-1:0]  root_o
);

  logic             valid_q;
  pipe_t            pipe_q;
  logic [63:0]      rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [65:0]      trial;
  logic [65:0]      rem_w;

  always_comb begin
    trial  = (66'(root_i) << (BIT + 1)) + (66'd1 << (2 * BIT));
    rem_w  = 66'(rem_i);
    rem_d  = rem_i;
    root_d = root_i;
    if (rem_w >= trial) begin
      rem_d       = 64'(rem_w - trial);
      root_d[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_i;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule

// ----- hdl/vau_div_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider step
// One restoring division step for each of the three vector components.
// ----------------------------------------------------------------------------
module vau_div_step import vau_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  pipe_t                 pipe_i,
  input  logic [RootW-1:0]      mag_i,
  input  logic [2:0]            nbit_i,
  input  logic [2:0][31:0]      rem_i,
  input  logic [2:0][QuotW-1:0] quot_i,
  output logic                  valid_o,
  output pipe_t                 pipe_o,
  output logic [RootW-1:0]      mag_o,
  output logic [2:0][31:0]      rem_o,
  output logic [2:0][QuotW-1:0] quot_o
);

  logic                  valid_q;
  pipe_t                 pipe_q;
  logic [RootW-1:0]      mag_q;
  logic [2:0][31:0]      rem_q, rem_d;
  logic [2:0][QuotW-1:0] quot_q, quot_d;
  logic [32:0]           rs;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rs = {rem_i[k], nbit_i[k]};
      if (rs >= {1'b0, mag_i}) begin
        rem_d[k]  = 32'(rs - {1'b0, mag_i});
        quot_d[k] = {quot_i[k][QuotW-2:0], 1'b1};
      end else begin
        rem_d[k]  = rs[31:0];
        quot_d[k] = {quot_i[k][QuotW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_i;
      mag_q  <= mag_i;
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;
  assign mag_o   = mag_q;
  assign rem_o   = rem_q;
  assign quot_o  = quot_q;

endmodule

// ----- hdl/vector3_arith_unit_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point 3D vector arithmetic unit
// Add, subtract, negate, scale, dot, cross, magnitude, normalize and null
// test on signed Q16.16 vectors, one result item for each input item.
//
//   Channel   Dir  Content
//   s_axis    in   tdata: a_x a_y a_z b_x b_y b_z scale_factor; tuser: op
//   m_axis    out  tdata: r_x r_y r_z scalar_out; tuser: flags
//   cfg       in   null_tolerance, written with cfg_we_i
//
// One item enters every cycle unless the output stalls; each item passes three front
// stages, 32 square root stages (one root bit each), 17 divider stages and the
// output register. Reset clears the valid bits and sets the tolerance to 66.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module vector3_arith_unit_core import vau_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [223:0] s_axis_tdata,  // a_x, a_y, a_z, b_x, b_y, b_z, scale_factor
  input  logic [3:0]   s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // r_x, r_y, r_z, scalar_out
  output logic [2:0]   m_axis_tuser,  // is_null, overflow, div_zero
  input  logic         cfg_we_i,
  input  logic [30:0]  cfg_wdata_i
);

  localparam int unsigned SqSteps = RootW;
  localparam int unsigned DvSteps = QuotW;

  logic        en;
  logic [30:0] tol_q;

  logic             out_valid_q;
  logic [127:0]     out_data_q, out_data_d;
  logic [2:0]       out_user_q, out_user_d;

  logic             sq_v    [SqSteps+1];
  pipe_t            sq_pipe [SqSteps+1];
  logic [63:0]      sq_rem  [SqSteps+1];
  logic [RootW-1:0] sq_root [SqSteps+1];

  logic                  dv_v    [DvSteps+1];
  pipe_t                 dv_pipe [DvSteps+1];
  logic [RootW-1:0]      dv_mag  [DvSteps+1];
  logic [2:0][31:0]      dv_rem  [DvSteps+1];
  logic [2:0][QuotW-1:0] dv_quot [DvSteps+1];
  logic [2:0][31:0]      a_abs;
  logic [2:0]            first_bits;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 31'd66;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  vau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .op_i    (s_axis_tuser),
    .a_i     ({s_axis_tdata[95:64], s_axis_tdata[63:32], s_axis_tdata[31:0]}),
    .b_i     ({s_axis_tdata[191:160], s_axis_tdata[159:128], s_axis_tdata[127:96]}),
    .s_i     (s_axis_tdata[223:192]),
    .valid_o (sq_v[0]),
    .pipe_o  (sq_pipe[0]),
    .sumsq_o (sq_rem[0])
  );

  assign sq_root[0] = '0;

  for (genvar i = 0; i < SqSteps; i++) begin : g_sqrt
    vau_sqrt_step #(.BIT(SqSteps - 1 - i)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[i]),
      .pipe_i  (sq_pipe[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .valid_o (sq_v[i+1]),
      .pipe_o  (sq_pipe[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_abs[k]      = sq_pipe[SqSteps].a[k][31] ? 32'(-sq_pipe[SqSteps].a[k])
                                                : sq_pipe[SqSteps].a[k];
      first_bits[k] = a_abs[k][0];
      dv_rem[0][k]  = a_abs[k] >> 1;
      dv_quot[0][k] = '0;
    end
  end

  assign dv_v[0]    = sq_v[SqSteps];
  assign dv_pipe[0] = sq_pipe[SqSteps];
  assign dv_mag[0]  = sq_root[SqSteps];

  for (genvar j = 0; j < DvSteps; j++) begin : g_div
    vau_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[j]),
      .pipe_i  (dv_pipe[j]),
      .mag_i   (dv_mag[j]),
      .nbit_i  ((j == 0) ? first_bits : 3'b000),
      .rem_i   (dv_rem[j]),
      .quot_i  (dv_quot[j]),
      .valid_o (dv_v[j+1]),
      .pipe_o  (dv_pipe[j+1]),
      .mag_o   (dv_mag[j+1]),
      .rem_o   (dv_rem[j+1]),
      .quot_o  (dv_quot[j+1])
    );
  end

  pipe_t            fin;
  logic [RootW-1:0] mag;
  logic [2:0][31:0] rv;
  logic [31:0]      sc;
  logic             ovf, isn, dz;

  always_comb begin
    fin = dv_pipe[DvSteps];
    mag = dv_mag[DvSteps];
    rv  = fin.r;
    sc  = fin.sc;
    ovf = fin.ov;
    isn = 1'b0;
    dz  = 1'b0;
    case (fin.op)
      OP_MAG: begin
        ovf = mag[RootW-1];
        sc  = mag[RootW-1] ? 32'h7FFF_FFFF : mag;
      end
      OP_NORM: begin
        if (mag == '0) begin
          dz = 1'b1;
          rv = '0;
        end else begin
          for (int k = 0; k < 3; k++) begin
            rv[k] = fin.a[k][31] ? 32'(-32'(dv_quot[DvSteps][k]))
                                 : 32'(dv_quot[DvSteps][k]);
          end
        end
      end
      OP_NULL: begin
        isn = mag < {1'b0, tol_q};
      end
      default: begin
      end
    endcase
    out_data_d = {sc, rv[2], rv[1], rv[0]};
    out_user_d = {dz, ovf, isn};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_v[DvSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTH
  a_dz_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata[95:0] == 96'd0 && !m_axis_tuser[1])
    else $error("divide-by-zero item carries a nonzero vector or overflow");
  a_null_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && !m_axis_tuser[2])
    else $error("null test item carries another flag");
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output register is empty");
`endif

endmodule

// ----- sim/vau_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector arithmetic unit checker
// Watches the input and output channels and the tolerance register, predicts
// the result of every accepted item and compares it field by field.
// ----------------------------------------------------------------------------
module vau_checker import vau_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [223:0] s_axis_tdata,
  input  logic [3:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [30:0]  cfg_wdata_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic [31:0] sc;
    logic        is_null;
    logic        ov;
    logic        dz;
  } vec_result_t;

  vec_result_t result_q[$];
  logic [30:0] tol_q;

  function automatic logic [63:0] clamp32(input logic signed [127:0] v, inout logic ov);
    if (v > 128'sd2147483647) begin
      ov = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -128'sd2147483648) begin
      ov = 1'b1;
      return -64'sd2147483648;
    end
    return 64'(v);
  endfunction

  function automatic logic [63:0] root_floor(input logic [127:0] n);
    logic [127:0] lo, hi, mid;
    lo = 0;
    hi = 128'h1_0000_0000_0000_0000;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= n) lo = mid;
      else hi = mid;
    end
    return lo[63:0];
  endfunction

  function automatic vec_result_t compute_result(input logic [223:0] d, input logic [3:0] op,
                                                 input logic [30:0] tol);
    logic signed [127:0] a[3], b[3], s, m, t, sum;
    vec_result_t res;
    logic [63:0] r[3];
    logic ov;
    logic [127:0] sq;
    res = '0;
    ov = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(d[32*i +: 32]);
      b[i] = $signed(d[96 + 32*i +: 32]);
      r[i] = 0;
    end
    s = $signed(d[192 +: 32]);
    sq = 0;
    for (int i = 0; i < 3; i++) sq += a[i] * a[i];
    m = $signed({64'd0, root_floor(sq)});
    case (op)
      OP_ADD: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + b[i], ov);
      OP_SUB: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] - b[i], ov);
      OP_NEG: for (int i = 0; i < 3; i++) r[i] = clamp32(-a[i], ov);
      OP_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp32((a[i] * s) >>> 16, ov);
      OP_DOT: begin
        sum = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        res.sc = 32'(clamp32(sum >>> 16, ov));
      end
      OP_CROSS: begin
        r[0] = clamp32((a[1] * b[2] - a[2] * b[1]) >>> 16, ov);
        r[1] = clamp32((a[2] * b[0] - a[0] * b[2]) >>> 16, ov);
        r[2] = clamp32((a[0] * b[1] - a[1] * b[0]) >>> 16, ov);
      end
      OP_MAG: res.sc = 32'(clamp32(m, ov));
      OP_NORM: begin
        if (m == 0) res.dz = 1'b1;
        else for (int i = 0; i < 3; i++) begin
          t = (a[i] * 65536) / m;
          r[i] = 64'(t);
        end
      end
      OP_NULL: res.is_null = m < $signed({97'd0, tol});
      default: ;
    endcase
    res.rx = r[0][31:0];
    res.ry = r[1][31:0];
    res.rz = r[2][31:0];
    res.ov = ov;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch %s got %h expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    vec_result_t e, g;
    if (!rst_ni) begin
      tol_q <= 31'd66;
    end else begin
      if (cfg_we_i) tol_q <= cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        result_q.push_back(compute_result(s_axis_tdata, s_axis_tuser, tol_q));
      if (m_axis_tvalid && m_axis_tready) begin
        g = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
             m_axis_tdata[127:96], m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[2]};
        if (result_q.size() == 0) begin
          report_mismatch("unexpected item", '0, '0);
        end else begin
          e = result_q.pop_front();
          if (g.rx !== e.rx) report_mismatch("r_x", g.rx, e.rx);
          if (g.ry !== e.ry) report_mismatch("r_y", g.ry, e.ry);
          if (g.rz !== e.rz) report_mismatch("r_z", g.rz, e.rz);
          if (g.sc !== e.sc) report_mismatch("scalar_out", g.sc, e.sc);
          if (g.is_null !== e.is_null)
            report_mismatch("is_null", 32'(g.is_null), 32'(e.is_null));
          if (g.ov !== e.ov) report_mismatch("overflow", 32'(g.ov), 32'(e.ov));
          if (g.dz !== e.dz) report_mismatch("div_zero", 32'(g.dz), 32'(e.dz));
        end
      end
      pending_o <= result_q.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector arithmetic unit testbench
// Drives directed and random items with bursty input and stalling output,
// changes the null tolerance between phases and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import vau_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata = '0;
  logic [3:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  logic [30:0]  cfg_wdata_i = '0;
  int           fail_count;
  int           pending;
  int           cycle_count = 0;
  logic         hold_off = 1'b0;
  logic         stall_free = 1'b0;

  localparam int CycleLimit = 400000;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  vector3_arith_unit_core dut (.*);

  vau_checker checker_i (.*, .fail_count_o(fail_count), .pending_o(pending));

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (stall_free) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 9) < 7);
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 40)) - 20);
      3: return 32'($signed($urandom_range(0, 400000)) - 200000);
      4: return 32'($signed($urandom_range(0, 20000000)) - 10000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [3:0] op, input logic [223:0] d);
    s_axis_tuser <= op;
    s_axis_tdata <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int count);
    logic [223:0] d;
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && count > 0) begin
        for (int i = 0; i < 7; i++) d[32*i +: 32] = pick_value();
        if ($urandom_range(0, 19) == 0) send_item(4'($urandom_range(9, 15)), d);
        else send_item(4'($urandom_range(0, 8)), d);
        burst--;
        count--;
      end
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0 || s_axis_tvalid) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_tolerance(input logic [30:0] v);
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [223:0] d;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed items: every opcode, field extremes and the special cases.
    for (int op = 0; op < 9; op++) begin
      d = {7{32'h7fff_ffff}};
      send_item(4'(op), d);
      d = {7{32'h8000_0000}};
      send_item(4'(op), d);
    end
    send_item(OP_NORM, '0);
    send_item(OP_NULL, '0);
    send_item(OP_NULL, {128'd0, 32'd0, 32'd0, 32'd65});
    send_item(OP_NULL, {128'd0, 32'd0, 32'd0, 32'd66});
    send_item(OP_SUB, {32'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 96'd0});
    send_item(OP_SCALE, {32'hffff_ffff, 96'd0, 32'hffff_ffff, 32'h1, 32'h3});
    send_item(4'd15, {7{32'h1234_5678}});
    s_axis_tvalid <= 1'b0;
    drain();
    // Long receiver hold-off while the sender keeps offering items.
    fork
      send_random(120);
      begin
        hold_off <= 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off <= 1'b0;
      end
    join
    drain();
    write_tolerance(31'd0);
    send_random(100);
    drain();
    write_tolerance(31'h7fff_ffff);
    send_random(100);
    drain();
    write_tolerance(31'd196608);
    stall_free <= 1'b1;
    send_random(100);
    stall_free <= 1'b0;
    drain();
    write_tolerance(31'($urandom));
    send_random(380);
    drain();
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/vau_pkg.sv
hdl/vau_front.sv
hdl/vau_sqrt_step.sv
hdl/vau_div_step.sv
hdl/vector3_arith_unit_core.sv
sim/vau_checker.sv
sim/testbench.sv
